[rtl/core/grepv_pkg.sv]
// grepv_pkg: shared types and constants for the gre header parse/verify block
// used by grepv_capture, grepv_verify and gre_header_parse_verify_top
package grepv_pkg;

   localparam int unsigned MAX_PACKET_BYTES = 65535;
   localparam int unsigned COUNT_W = 16;

   localparam logic [15:0] FLAG_C = 16'h8000;
   localparam logic [15:0] FLAG_K = 16'h2000;
   localparam logic [15:0] FLAG_S = 16'h1000;
   localparam logic [15:0] RESERVED_MASK = 16'h4C00;
   localparam logic [15:0] VERSION_MASK = 16'h0007;

   localparam logic [15:0] PROTO_TEB = 16'h6558;
   localparam logic [15:0] PROTO_ARP = 16'h0806;
   localparam logic [15:0] PROTO_IPV4 = 16'h0800;
   localparam logic [15:0] PROTO_IPV6 = 16'h86DD;

   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_PACKET_BYTES);

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_SHORT     = 3'd1,
      ERR_PROTO     = 3'd2,
      ERR_VERSION   = 3'd3,
      ERR_RESERVED  = 3'd4,
      ERR_CHECKSUM  = 3'd5,
      ERR_TRUNCATED = 3'd6
   } err_type;

   // packet state after the current word has been folded in
   typedef struct packed {
      logic [COUNT_W-1:0] byte_count;
      logic [15:0]        flag_word;
      logic [15:0]        proto_word;
      logic [15:0]        rcv_csum;
      logic [31:0]        key_word;
      logic [31:0]        seq_word;
      logic [15:0]        sum;
   } pkt_state_type;

   typedef struct packed {
      logic        accepted;
      logic [2:0]  error_code;
      logic        checksum_present;
      logic        key_present;
      logic        sequence_present;
      logic [31:0] tunnel_key;
      logic [31:0] sequence_number;
      logic [15:0] protocol_type;
      logic [4:0]  header_length;
      logic [15:0] payload_length;
   } result_type;

endpackage

[rtl/core/grepv_capture.sv]
// grepv_capture: per-packet header field capture and ones'-complement sum
// depends on grepv_pkg
module grepv_capture
   import grepv_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  logic [7:0]    data_byte,
   input  logic          last_byte,
   output pkt_state_type nxt
);

   pkt_state_type state_ff, state_in;
   logic [7:0]  pending_ff, pending_in;

   logic [COUNT_W-1:0] pos;
   logic        taken, has_c, has_k, has_s;
   logic [COUNT_W-1:0] key_at, seq_at;
   logic [7:0]  word_byte;
   logic        add_en;
   logic [15:0] add_word;
   logic [16:0] sum_wide;

   always_comb begin
      pos    = state_ff.byte_count;
      taken  = (pos != COUNT_MAX);
      has_c  = |(state_ff.flag_word & FLAG_C);
      has_k  = |(state_ff.flag_word & FLAG_K);
      has_s  = |(state_ff.flag_word & FLAG_S);
      key_at = has_c ? COUNT_W'(8) : COUNT_W'(4);
      seq_at = has_k ? key_at + COUNT_W'(4) : key_at;

      nxt        = state_ff;
      pending_in = pending_ff;
      word_byte  = data_byte;

      if (taken) begin
         nxt.byte_count = pos + COUNT_W'(1);
         if (pos == COUNT_W'(0)) nxt.flag_word[15:8] = data_byte;
         if (pos == COUNT_W'(1)) nxt.flag_word[7:0] = data_byte;
         if (pos == COUNT_W'(2)) nxt.proto_word[15:8] = data_byte;
         if (pos == COUNT_W'(3)) nxt.proto_word[7:0] = data_byte;
         // checksum field counts as zero in the sum
         if (has_c && (pos == COUNT_W'(4) || pos == COUNT_W'(5))) begin
            nxt.rcv_csum = {state_ff.rcv_csum[7:0], data_byte};
            word_byte    = 8'h00;
         end
         if (has_k && pos >= key_at && pos < key_at + COUNT_W'(4)) begin
            nxt.key_word = {state_ff.key_word[23:0], data_byte};
         end
         if (has_s && pos >= seq_at && pos < seq_at + COUNT_W'(4)) begin
            nxt.seq_word = {state_ff.seq_word[23:0], data_byte};
         end
      end

      // at most one word add per byte: odd bytes close a word, a last even
      // byte (or a saturated count, always odd) pads with a zero low byte
      add_en   = 1'b0;
      add_word = 16'h0000;
      if (taken && pos[0]) begin
         add_en   = 1'b1;
         add_word = {pending_ff, word_byte};
      end else if (taken) begin
         pending_in = word_byte;
         if (last_byte) begin
            add_en   = 1'b1;
            add_word = {word_byte, 8'h00};
         end
      end else if (last_byte) begin
         add_en   = 1'b1;
         add_word = {pending_ff, 8'h00};
      end

      sum_wide = {1'b0, state_ff.sum} + {1'b0, add_word};
      if (add_en) begin
         nxt.sum = sum_wide[15:0] + {15'h0000, sum_wide[16]};
      end

      state_in = state_ff;
      if (step) begin
         state_in = last_byte ? '0 : nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= '0;
         pending_ff <= 8'h00;
      end else begin
         state_ff   <= state_in;
         pending_ff <= (step && last_byte) ? 8'h00 : (step ? pending_in : pending_ff);
      end
   end

endmodule

[rtl/core/grepv_verify.sv]
// grepv_verify: end-of-packet checks and result formatting
// depends on grepv_pkg
module grepv_verify
   import grepv_pkg::*;
(
   input  pkt_state_type pkt,
   input  logic          require_teb,
   output result_type    res
);

   logic        has_c, has_k, has_s, proto_ok;
   logic [4:0]  hdr;
   logic [15:0] computed;
   err_type     err;

   always_comb begin
      has_c = |(pkt.flag_word & FLAG_C);
      has_k = |(pkt.flag_word & FLAG_K);
      has_s = |(pkt.flag_word & FLAG_S);
      hdr   = 5'd4 + (has_c ? 5'd4 : 5'd0) + (has_k ? 5'd4 : 5'd0)
            + (has_s ? 5'd4 : 5'd0);
      computed = ~pkt.sum;

      proto_ok = (pkt.proto_word == PROTO_TEB) ||
                 (!require_teb && (pkt.proto_word == PROTO_ARP ||
                                   pkt.proto_word == PROTO_IPV4 ||
                                   pkt.proto_word == PROTO_IPV6));

      if (pkt.byte_count <= COUNT_W'(4))                  err = ERR_SHORT;
      else if (!proto_ok)                                 err = ERR_PROTO;
      else if (|(pkt.flag_word & VERSION_MASK))           err = ERR_VERSION;
      else if (|(pkt.flag_word & RESERVED_MASK))          err = ERR_RESERVED;
      else if (pkt.byte_count < COUNT_W'(hdr))            err = ERR_TRUNCATED;
      else if (has_c && computed != pkt.rcv_csum)         err = ERR_CHECKSUM;
      else                                                err = ERR_NONE;

      res.accepted         = (err == ERR_NONE);
      res.error_code       = err;
      res.checksum_present = has_c;
      res.key_present      = has_k;
      res.sequence_present = has_s;
      res.tunnel_key       = (err == ERR_NONE && has_k) ? pkt.key_word : 32'h0;
      res.sequence_number  = (err == ERR_NONE && has_s) ? pkt.seq_word : 32'h0;
      res.protocol_type    = pkt.proto_word;
      res.header_length    = hdr;
      // no error implies the count covers the header
      res.payload_length   = (err == ERR_NONE) ? pkt.byte_count - COUNT_W'(hdr) : 16'h0;
   end

endmodule

[rtl/core/gre_header_parse_verify_top.sv]
// gre_header_parse_verify_top: byte-serial gre header parser and checksum verifier
// depends on grepv_pkg, grepv_capture, grepv_verify
//
// Usage:
//   req channel: one packet byte per word (req_data_byte) in wire order from the
//   first gre header byte, req_last_byte marks the final byte. A word is taken
//   when req_valid is high and req_stall is low.
//   rsp channel: one result word per packet, presented after the final byte.
//   csr port: csr_wr_en writes csr_wr_data into require_teb (reset value 1);
//   write only while no packet is in flight.
//   Throughput: one byte per cycle while req_stall is low, set by the single capture stage
//   (field capture plus one 16-bit end-around add per byte).
//   Result path: the final byte passes from the input register into the result
//   register, which presents the result word until it is taken at an edge with
//   rsp_stall low.
//   Stall: when rsp_stall holds a waiting result, the input register still
//   takes non-final bytes; a final byte waits in the input register, and
//   req_stall rises only while that byte cannot move into the result register.
//   Reset: synchronous, active high; clears all packet state, empties both
//   registers and sets require_teb.
module gre_header_parse_verify_top
   import grepv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_accepted,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_checksum_present,
   output logic        rsp_key_present,
   output logic        rsp_sequence_present,
   output logic [31:0] rsp_tunnel_key,
   output logic [31:0] rsp_sequence_number,
   output logic [15:0] rsp_protocol_type,
   output logic [4:0]  rsp_header_length,
   output logic [15:0] rsp_payload_length
);

   logic       require_teb_ff;
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff;

   logic          out_free, advance, req_take;
   pkt_state_type pkt_nxt;
   result_type    res;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_last_ff || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   grepv_capture u_capture (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .nxt       (pkt_nxt)
   );

   grepv_verify u_verify (
      .pkt         (pkt_nxt),
      .require_teb (require_teb_ff),
      .res         (res)
   );

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = (advance && in_last_ff) ? 1'b1 : (out_free ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         require_teb_ff <= 1'b1;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) require_teb_ff <= csr_wr_data;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && in_last_ff) begin
         out_ff <= res;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_accepted         = out_ff.accepted;
   assign rsp_error_code       = out_ff.error_code;
   assign rsp_checksum_present = out_ff.checksum_present;
   assign rsp_key_present      = out_ff.key_present;
   assign rsp_sequence_present = out_ff.sequence_present;
   assign rsp_tunnel_key       = out_ff.tunnel_key;
   assign rsp_sequence_number  = out_ff.sequence_number;
   assign rsp_protocol_type    = out_ff.protocol_type;
   assign rsp_header_length    = out_ff.header_length;
   assign rsp_payload_length   = out_ff.payload_length;

endmodule
